>>> rtl/alu_shifter_flags_datapath_unit_assert.svh
// ----------------------------------------------------------------------------
// ALU datapath assertion macros
// Property wrappers used by the datapath top level.
// ----------------------------------------------------------------------------
`ifndef ALU_SHIFTER_FLAGS_DATAPATH_UNIT_ASSERT_SVH
`define ALU_SHIFTER_FLAGS_DATAPATH_UNIT_ASSERT_SVH

// same-cycle implication
`define ASFD_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define ASFD_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> rtl/asfd_pkg.sv
// ----------------------------------------------------------------------------
// ALU datapath package
// Operation codes, shift kinds and the status flag record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asfd_pkg;

   typedef enum logic [3:0] {
      MODE_ADD  = 4'd0,
      MODE_ADC  = 4'd1,
      MODE_SUB  = 4'd2,
      MODE_SBC  = 4'd3,
      MODE_CMP  = 4'd4,
      MODE_NEG  = 4'd5,
      MODE_XOR  = 4'd6,
      MODE_LD   = 4'd7,
      MODE_OR   = 4'd8,
      MODE_AND  = 4'd9,
      MODE_TST  = 4'd10,
      MODE_MULU = 4'd11,
      MODE_MULS = 4'd12
   } mode_type;

   typedef enum logic [2:0] {
      SHIFT_NONE = 3'd0,
      SHIFT_LSL  = 3'd1,
      SHIFT_LSR  = 3'd2,
      SHIFT_ROL  = 3'd3,
      SHIFT_ROR  = 3'd4,
      SHIFT_ASR  = 3'd5
   } shift_kind_type;

   typedef struct packed {
      logic n;
      logic z;
      logic s;
      logic c;
   } flags_type;

   localparam int unsigned WORD_W   = 16;
   localparam int unsigned SBUF_W   = 4;
   localparam logic [2:0]  MAX_SHIFT = 3'd4;

endpackage

>>> rtl/alu_shifter_flags_datapath_unit.sv
// ----------------------------------------------------------------------------
// ALU shifter flags datapath unit
// 16-bit ALU with nibble shift extension, NZSC flags and 16x16 multiplies.
// ----------------------------------------------------------------------------
//  channel | ports                  | contents
//  --------+------------------------+------------------------------------------
//  request | req_tvalid/tready/...  | tdata: operand_a, operand_b, shift_kind,
//          |                        |   shift_amount, update_flags; tuser: mode
//  result  | rsp_tvalid/tready/...  | tdata: result_word, product_high,
//          |                        |   write_back, N, Z, S, C, shift buffer
//
//  One request per cycle unless stalled; input register, then result register.
//  Shift buffer and flags (if update_flags) update as an ALU-mode result registers.
//  Synchronous active-high reset clears flags, shift buffer and valids.
//  A stalled result holds; the input register still takes a request if the
//  result register drains in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alu_shifter_flags_datapath_unit_assert.svh"

module alu_shifter_flags_datapath_unit
   import asfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] operand_a, [31:16] operand_b, [34:32] shift_kind,
   // [37:35] shift_amount, [38] update_flags, [39] zero
   input  logic [39:0] req_tdata,
   // [3:0] mode
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] result_word, [31:16] product_high, [32] write_back, [33] neg_flag,
   // [34] zero_flag, [35] sign_flag, [36] carry_flag, [40:37] shift_buffer_out,
   // [47:41] zero
   output logic [47:0] rsp_tdata
);

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [3:0]        s1_mode_ff;
   logic [15:0]       s1_a_ff, s1_b_ff;
   logic [2:0]        s1_kind_ff, s1_amt_ff;
   logic              s1_upd_ff;

   // state
   flags_type         flags_ff, flags_in;
   logic [SBUF_W-1:0] sbuf_ff, sbuf_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [15:0]       out_res_ff, out_res_in;
   logic [15:0]       out_hi_ff, out_hi_in;
   logic              out_wb_ff, out_wb_in;

   logic              s1_move;
   logic              req_fire;

   logic [15:0]       b_shifted;
   logic [SBUF_W-1:0] sbuf_shift;

   logic [15:0]       bx;
   logic              cin;
   logic [16:0]       sum;
   logic [16:0]       r;
   logic              arith;
   logic              alu_mode;
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] prod;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;

   asfd_shift u_shift (
      .operand  (s1_b_ff),
      .kind     (s1_kind_ff),
      .amount   (s1_amt_ff),
      .sbuf_cur (sbuf_ff),
      .shifted  (b_shifted),
      .sbuf_nxt (sbuf_shift)
   );

   assign alu_mode = (s1_mode_ff <= MODE_TST);
   assign mul_a = signed'({(s1_mode_ff == MODE_MULS) & s1_a_ff[15], s1_a_ff});
   assign mul_b = signed'({s1_b_ff[15], s1_b_ff});
   assign prod  = mul_a * mul_b;

   always_comb begin
      bx    = b_shifted;
      cin   = 1'b0;
      arith = 1'b0;
      r     = '0;
      case (s1_mode_ff) inside
         MODE_ADD: begin
            arith = 1'b1;
         end
         MODE_ADC: begin
            cin   = flags_ff.c;
            arith = 1'b1;
         end
         MODE_SUB, MODE_CMP: begin
            bx    = ~b_shifted;
            cin   = 1'b1;
            arith = 1'b1;
         end
         MODE_SBC: begin
            bx    = ~b_shifted;
            cin   = flags_ff.c;
            arith = 1'b1;
         end
         default: begin
            bx    = b_shifted;
         end
      endcase
      sum = {1'b0, s1_a_ff} + {1'b0, bx} + {16'd0, cin};
      case (s1_mode_ff) inside
         MODE_NEG:          r = {1'b0, 16'd0 - b_shifted};
         MODE_XOR:          r = {1'b0, s1_a_ff ^ b_shifted};
         MODE_LD:           r = {1'b0, b_shifted};
         MODE_OR:           r = {1'b0, s1_a_ff | b_shifted};
         MODE_AND, MODE_TST: r = {1'b0, s1_a_ff & b_shifted};
         default:           r = sum;
      endcase
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      flags_in     = flags_ff;
      sbuf_in      = sbuf_ff;
      out_res_in   = out_res_ff;
      out_hi_in    = out_hi_ff;
      out_wb_in    = out_wb_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
         out_res_in   = '0;
         out_hi_in    = '0;
         out_wb_in    = 1'b0;
         if (alu_mode) begin
            sbuf_in    = sbuf_shift;
            out_res_in = r[15:0];
            out_wb_in  = (s1_mode_ff != MODE_CMP) && (s1_mode_ff != MODE_TST);
            if (s1_upd_ff) begin
               flags_in.n = r[15];
               flags_in.z = (r[15:0] == 16'd0);
               if (arith) begin
                  flags_in.s = r[16] ^ (s1_a_ff[15] ^ bx[15]);
                  flags_in.c = r[16];
               end
            end
         end else if ((s1_mode_ff == MODE_MULU) || (s1_mode_ff == MODE_MULS)) begin
            out_res_in = prod[15:0];
            out_hi_in  = prod[31:16];
            out_wb_in  = 1'b1;
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         sbuf_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
         sbuf_ff      <= sbuf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_a_ff    <= req_tdata[15:0];
         s1_b_ff    <= req_tdata[31:16];
         s1_kind_ff <= req_tdata[34:32];
         s1_amt_ff  <= req_tdata[37:35];
         s1_upd_ff  <= req_tdata[38];
         s1_mode_ff <= req_tuser;
      end
      out_res_ff <= out_res_in;
      out_hi_ff  <= out_hi_in;
      out_wb_ff  <= out_wb_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, sbuf_ff, flags_ff.c, flags_ff.s, flags_ff.z, flags_ff.n,
                        out_wb_ff, out_hi_ff, out_res_ff};

   `ASFD_ASSERT_NXT(a_state_hold, clock, reset, !s1_move, $stable(flags_ff) && $stable(sbuf_ff))
   `ASFD_ASSERT_NXT(a_move_gives_rsp, clock, reset, s1_move, rsp_tvalid)
   `ASFD_ASSERT_NXT(a_mul_keeps_state, clock, reset,
      s1_move && ((s1_mode_ff == MODE_MULU) || (s1_mode_ff == MODE_MULS)),
      $stable(flags_ff) && $stable(sbuf_ff) && out_wb_ff)
   `ASFD_ASSERT_IMP(a_no_accept_when_full, clock, reset,
      s1_valid_ff && out_valid_ff && !rsp_tready, !req_tready)

endmodule

>>> rtl/asfd_shift.sv
// ----------------------------------------------------------------------------
// ALU datapath operand shifter
// 0-4 bit shift/rotate of operand B through the 4-bit extension buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asfd_shift
   import asfd_pkg::*;
(
   input  logic [WORD_W-1:0] operand,
   input  logic [2:0]        kind,
   input  logic [2:0]        amount,
   input  logic [SBUF_W-1:0] sbuf_cur,
   output logic [WORD_W-1:0] shifted,
   output logic [SBUF_W-1:0] sbuf_nxt
);

   logic [2:0]  amt;
   logic [19:0] wide20;
   logic [23:0] wide24;

   always_comb begin
      amt      = (amount > MAX_SHIFT) ? MAX_SHIFT : amount;
      wide20   = '0;
      wide24   = '0;
      shifted  = operand;
      sbuf_nxt = sbuf_cur;
      case (kind)
         SHIFT_LSL: begin
            wide20   = {sbuf_cur, operand} << amt;
            shifted  = wide20[15:0];
            sbuf_nxt = wide20[19:16];
         end
         SHIFT_LSR: begin
            wide20   = {operand, sbuf_cur} >> amt;
            shifted  = wide20[19:4];
            sbuf_nxt = wide20[3:0];
         end
         SHIFT_ROL: begin
            wide24   = {sbuf_cur, operand, sbuf_cur} << amt;
            shifted  = wide24[19:4];
            sbuf_nxt = wide24[23:20];
         end
         SHIFT_ROR: begin
            wide24   = {sbuf_cur, operand, sbuf_cur} >> amt;
            shifted  = wide24[19:4];
            sbuf_nxt = wide24[3:0];
         end
         SHIFT_ASR: begin
            wide24   = {{4{operand[15]}}, operand, sbuf_cur} >> amt;
            shifted  = wide24[19:4];
            sbuf_nxt = wide24[3:0];
         end
         default: begin
            shifted  = operand;
            sbuf_nxt = sbuf_cur;
         end
      endcase
   end

endmodule

>>> bench/alu_shifter_flags_datapath_unit_test.sv
// ----------------------------------------------------------------------------
// ALU shifter flags datapath unit testbench
// Streams ALU, shift and multiply requests into the datapath and checks every
// response against an in-bench predictor of the result word, product high
// word, write-back, NZSC flags and shift buffer, under random idling on both
// sides, a long result stall and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alu_shifter_flags_datapath_unit_test
   import asfd_pkg::*;
();

   localparam logic [3:0] MODE_NOP_TOP = 4'hf;
   localparam logic [2:0] SHIFT_SPARE  = 3'd7;
   localparam int unsigned RANDOM_OPS  = 850;
   localparam int unsigned STALL_AT    = 300;
   localparam int unsigned STALL_LEN   = 80;
   localparam int unsigned QUIET_LO    = 500;
   localparam int unsigned QUIET_HI    = 640;

   typedef struct packed {
      logic        pad;
      logic        update_flags;
      logic [2:0]  shift_amount;
      logic [2:0]  shift_kind;
      logic [15:0] operand_b;
      logic [15:0] operand_a;
   } req_word_type;

   typedef struct packed {
      logic         drain;
      logic [3:0]   mode;
      req_word_type word;
   } alu_op_type;

   typedef struct packed {
      logic [6:0]  pad;
      logic [3:0]  shift_buf;
      logic        carry;
      logic        sign;
      logic        zero;
      logic        neg;
      logic        write_back;
      logic [15:0] prod_high;
      logic [15:0] result;
   } alu_result_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata    = '0;
   logic [3:0]  req_tuser    = '0;
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [47:0] rsp_tdata;

   alu_op_type     alu_ops_todo[$];
   alu_result_type alu_results_due[$];
   alu_op_type     op_in_flight;

   flags_type   flags_q     = '0;
   logic [3:0]  shift_buf_q = '0;

   int unsigned accepted_cnt = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;
   int unsigned fail_count   = 0;

   alu_shifter_flags_datapath_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // predictor: advances flags and shift buffer, queues the expected response
   task automatic compute_alu_result(input alu_op_type op);
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] bs;
      logic [15:0] bx;
      logic [16:0] r;
      logic [31:0] v;
      logic [31:0] p;
      logic [3:0]  sb;
      logic [2:0]  amt;
      logic        arith;
      alu_result_type e;
      a = op.word.operand_a;
      b = op.word.operand_b;
      e = '0;
      if (op.mode <= MODE_TST) begin
         amt = (op.word.shift_amount > MAX_SHIFT) ? MAX_SHIFT : op.word.shift_amount;
         sb = shift_buf_q;
         bs = b;
         case (op.word.shift_kind)
            SHIFT_LSL: begin
               v = {12'b0, sb, b} << amt;
               sb = v[19:16];
               bs = v[15:0];
            end
            SHIFT_LSR: begin
               v = {12'b0, b, sb} >> amt;
               sb = v[3:0];
               bs = v[19:4];
            end
            SHIFT_ROL: begin
               v = {8'b0, sb, b, sb} << amt;
               sb = v[23:20];
               bs = v[19:4];
            end
            SHIFT_ROR: begin
               v = {8'b0, sb, b, sb} >> amt;
               sb = v[3:0];
               bs = v[19:4];
            end
            SHIFT_ASR: begin
               v = {8'b0, {4{b[15]}}, b, sb} >> amt;
               sb = v[3:0];
               bs = v[19:4];
            end
            default: ;
         endcase
         shift_buf_q = sb;
         bx = bs;
         arith = 1'b1;
         e.write_back = 1'b1;
         case (op.mode)
            MODE_ADD: r = a + bs;
            MODE_ADC: r = a + bs + flags_q.c;
            MODE_SUB: begin
               bx = ~bs;
               r = a + bx + 1'b1;
            end
            MODE_SBC: begin
               bx = ~bs;
               r = a + bx + flags_q.c;
            end
            MODE_CMP: begin
               bx = ~bs;
               r = a + bx + 1'b1;
               e.write_back = 1'b0;
            end
            MODE_NEG: begin
               r = {1'b0, 16'(-bs)};
               arith = 1'b0;
            end
            MODE_XOR: begin
               r = {1'b0, a ^ bs};
               arith = 1'b0;
            end
            MODE_LD: begin
               r = {1'b0, bs};
               arith = 1'b0;
            end
            MODE_OR: begin
               r = {1'b0, a | bs};
               arith = 1'b0;
            end
            MODE_AND: begin
               r = {1'b0, a & bs};
               arith = 1'b0;
            end
            default: begin
               r = {1'b0, a & bs};
               arith = 1'b0;
               e.write_back = 1'b0;
            end
         endcase
         if (op.word.update_flags) begin
            flags_q.n = r[15];
            flags_q.z = (r[15:0] == 16'h0000);
            if (arith) begin
               flags_q.s = r[16] ^ a[15] ^ bx[15];
               flags_q.c = r[16];
            end
         end
         e.result = r[15:0];
      end else if (op.mode == MODE_MULU || op.mode == MODE_MULS) begin
         p = {16'b0, a} * {16'b0, b};
         if (b[15]) p = p - {a, 16'b0};
         if (op.mode == MODE_MULS && a[15]) p = p - {b, 16'b0};
         e.result = p[15:0];
         e.prod_high = p[31:16];
         e.write_back = 1'b1;
      end
      e.neg = flags_q.n;
      e.zero = flags_q.z;
      e.sign = flags_q.s;
      e.carry = flags_q.c;
      e.shift_buf = shift_buf_q;
      alu_results_due.push_back(e);
   endtask

   task automatic add_op(input logic [3:0] mode, input logic [15:0] a, input logic [15:0] b,
                         input logic [2:0] kind, input logic [2:0] amt, input logic upd,
                         input logic drain);
      alu_op_type op;
      op = '0;
      op.drain = drain;
      op.mode = mode;
      op.word.operand_a = a;
      op.word.operand_b = b;
      op.word.shift_kind = kind;
      op.word.shift_amount = amt;
      op.word.update_flags = upd;
      alu_ops_todo.push_back(op);
   endtask

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : driver_proc
      bit quiet;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            compute_alu_result(op_in_flight);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_tvalid || req_tready) begin
            quiet = (accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI) || hold_left != 0;
            if (alu_ops_todo.size() != 0 &&
                !(alu_ops_todo[0].drain && alu_results_due.size() != 0) &&
                (quiet || $urandom_range(0, 99) >= 34)) begin
               op_in_flight = alu_ops_todo.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= op_in_flight.word;
               req_tuser <= op_in_flight.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long result stall, sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && accepted_cnt >= STALL_AT) begin
         hold_left <= STALL_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor_proc
      alu_result_type got;
      alu_result_type exp;
      bit             bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (alu_results_due.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10)
                  $display("unexpected response %h", rsp_tdata);
            end else begin
               exp = alu_results_due.pop_front();
               bad = (got.result !== exp.result) || (got.prod_high !== exp.prod_high) ||
                     (got.write_back !== exp.write_back) || (got.neg !== exp.neg) ||
                     (got.zero !== exp.zero) || (got.sign !== exp.sign) ||
                     (got.carry !== exp.carry) || (got.shift_buf !== exp.shift_buf) ||
                     (got.pad !== exp.pad);
               if (bad) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("mismatch: expected %h actual %h", exp, got);
               end
            end
         end
         rsp_tready <= (hold_left == 0) &&
                       ((accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI) ||
                        $urandom_range(0, 99) >= 34);
      end
   end

   initial begin : stimulus_proc
      logic [3:0]  mode;
      logic [2:0]  kind;
      logic [2:0]  amt;
      // directed: carries, overflow, every op, shifts, odd sizes, multiplies
      add_op(MODE_ADD,  16'hffff, 16'h0001, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_ADC,  16'h0000, 16'h0000, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_ADD,  16'h7fff, 16'h0001, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_SUB,  16'h1234, 16'h1234, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_SBC,  16'h0000, 16'h0001, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_SBC,  16'h8000, 16'h0001, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_CMP,  16'h0005, 16'h0009, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_NEG,  16'h0000, 16'h8000, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_NEG,  16'hffff, 16'h0000, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_XOR,  16'haaaa, 16'h5555, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_LD,   16'h0000, 16'h8001, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_OR,   16'h0f0f, 16'hf0f0, SHIFT_NONE, 3'd1, 1'b0, 1'b0);
      add_op(MODE_AND,  16'hffff, 16'h0000, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_TST,  16'hffff, 16'h8000, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_LD,   16'h0000, 16'hf00f, SHIFT_LSL,  3'd4, 1'b1, 1'b0);
      add_op(MODE_LD,   16'h0000, 16'h1234, SHIFT_LSR,  3'd3, 1'b1, 1'b0);
      add_op(MODE_ADD,  16'h0001, 16'h8421, SHIFT_ROL,  3'd2, 1'b1, 1'b0);
      add_op(MODE_SUB,  16'hffff, 16'h0003, SHIFT_ROR,  3'd1, 1'b1, 1'b0);
      add_op(MODE_LD,   16'h0000, 16'h8000, SHIFT_ASR,  3'd4, 1'b1, 1'b0);
      add_op(MODE_LD,   16'h0000, 16'hbeef, SHIFT_LSL,  3'd0, 1'b1, 1'b0);
      add_op(MODE_OR,   16'h0000, 16'h1111, SHIFT_ROR,  3'd7, 1'b1, 1'b0);
      add_op(MODE_XOR,  16'hffff, 16'h00ff, SHIFT_SPARE, 3'd2, 1'b1, 1'b0);
      add_op(MODE_MULU, 16'hffff, 16'hffff, SHIFT_LSL,  3'd2, 1'b1, 1'b0);
      add_op(MODE_MULS, 16'h8000, 16'h8000, SHIFT_NONE, 3'd1, 1'b1, 1'b0);
      add_op(MODE_MULS, 16'hffff, 16'h0001, SHIFT_NONE, 3'd1, 1'b0, 1'b0);
      add_op(MODE_NOP_TOP, 16'hffff, 16'hffff, SHIFT_LSL, 3'd4, 1'b1, 1'b0);
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if ($urandom_range(0, 99) < 5)
            mode = 4'($urandom_range(MODE_MULS + 1, MODE_NOP_TOP));
         else
            mode = 4'($urandom_range(MODE_ADD, MODE_MULS));
         if ($urandom_range(0, 99) < 6)
            kind = 3'($urandom_range(SHIFT_ASR + 1, SHIFT_SPARE));
         else
            kind = 3'($urandom_range(SHIFT_NONE, SHIFT_ASR));
         case ($urandom_range(0, 19))
            0:       amt = 3'd0;
            1:       amt = 3'($urandom_range(5, 7));
            default: amt = 3'($urandom_range(1, 4));
         endcase
         add_op(mode, pick_operand(), pick_operand(), kind, amt,
                $urandom_range(0, 3) != 0, i == 0 || i == 450);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (alu_ops_todo.size() != 0 || req_tvalid)
         @(posedge clock);
      while (alu_results_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      fail_count = fail_count + alu_results_due.size();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/asfd_pkg.sv
rtl/asfd_shift.sv
rtl/alu_shifter_flags_datapath_unit.sv
bench/alu_shifter_flags_datapath_unit_test.sv
